@@ src/fd_pkg.sv @@
// Shared types and constants for the foldback distortion block.
// No dependencies; compiled first.
package fd_pkg;

	typedef struct packed {
		logic valid;
		logic pass;
	} fd_ctl_t;

	localparam fd_ctl_t FD_CTL_IDLE = '{valid: 1'b0, pass: 1'b0};

endpackage

@@ src/fd_if.sv @@
// Valid/ready stream interfaces for input samples and folded samples.
// Depends on nothing; compiled after fd_pkg.
interface fd_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface fd_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

@@ src/fd_cell.sv @@
// One restoring remainder cell: shifts in one dividend bit, subtracts the modulus if it fits.
// Depends on fd_pkg.
module fd_cell
	import fd_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [SAMPLE_BITS:0]   modulus,
	input  fd_ctl_t                ctl_i,
	input  logic [SAMPLE_BITS:0]   rem_i,
	input  logic [SAMPLE_BITS:0]   div_i,
	input  logic [SAMPLE_BITS-1:0] samp_i,
	output fd_ctl_t                ctl_o,
	output logic [SAMPLE_BITS:0]   rem_o,
	output logic [SAMPLE_BITS:0]   div_o,
	output logic [SAMPLE_BITS-1:0] samp_o
);

	localparam int W = SAMPLE_BITS + 1;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic [W-1:0] rem_next;

	fd_ctl_t              ctl_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         div_q;
	logic [SAMPLE_BITS-1:0] samp_q;

	assign trial    = {rem_i, div_i[W-1]};
	assign diff     = trial - {1'b0, modulus};
	assign rem_next = (trial >= {1'b0, modulus}) ? diff[W-1:0] : trial[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= FD_CTL_IDLE;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_next;
			div_q  <= {div_i[W-2:0], 1'b0};
			samp_q <= samp_i;
		end
	end

	assign ctl_o  = ctl_q;
	assign rem_o  = rem_q;
	assign div_o  = div_q;
	assign samp_o = samp_q;

endmodule

@@ src/foldback_distortion.sv @@
// Foldback distortion: an accepted sample passes the front-stage register, the remainder cells and the output register.
// Throughput one item per cycle; a row of SAMPLE_BITS+1 remainder cells, one dividend bit each,
// forms the pipeline, and the whole row stalls together while a finished item waits.
// Reset (arst_n low, asynchronous) clears all valid flags and the threshold to zero.
// Depends on fd_pkg, fd_if and fd_cell.
module foldback_distortion
	import fd_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SAMPLE_BITS-2:0] cfg_wdata,
	fd_in_if.sink                  sample_ch,
	fd_out_if.source               folded_ch
);

	localparam int W = SAMPLE_BITS + 1;

	logic [SAMPLE_BITS-2:0] thresh_q;
	logic                   en;
	logic [W-1:0]           modulus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	assign modulus = {thresh_q, 2'b00};

	// front stage: offset, magnitude and band check
	logic signed [W-1:0] s_ext;
	logic signed [W-1:0] t_ext;
	logic signed [W-1:0] d_val;
	logic [W-1:0]        d_mag;
	logic                in_band;

	fd_ctl_t                ctl_s1;
	logic [W-1:0]           mag_s1;
	logic [SAMPLE_BITS-1:0] samp_s1;

	assign s_ext   = {sample_ch.sample_in[SAMPLE_BITS-1], sample_ch.sample_in};
	assign t_ext   = $signed({2'b00, thresh_q});
	assign d_val   = s_ext - t_ext;
	assign d_mag   = d_val[W-1] ? (W)'(-d_val) : d_val;
	assign in_band = (s_ext <= t_ext) && (s_ext >= -t_ext);

	assign en              = !folded_ch.valid || folded_ch.ready;
	assign sample_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= FD_CTL_IDLE;
		end else if (en) begin
			ctl_s1.valid <= sample_ch.valid;
			ctl_s1.pass  <= in_band;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= d_mag;
			samp_s1 <= sample_ch.sample_in;
		end
	end

	// remainder chain
	fd_ctl_t                ctl_c  [0:W];
	logic [W-1:0]           rem_c  [0:W];
	logic [W-1:0]           div_c  [0:W];
	logic [SAMPLE_BITS-1:0] samp_c [0:W];

	assign ctl_c[0]  = ctl_s1;
	assign rem_c[0]  = '0;
	assign div_c[0]  = mag_s1;
	assign samp_c[0] = samp_s1;

	for (genvar i = 0; i < W; i++) begin : g_cell
		fd_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.modulus (modulus),
			.ctl_i   (ctl_c[i]),
			.rem_i   (rem_c[i]),
			.div_i   (div_c[i]),
			.samp_i  (samp_c[i]),
			.ctl_o   (ctl_c[i+1]),
			.rem_o   (rem_c[i+1]),
			.div_o   (div_c[i+1]),
			.samp_o  (samp_c[i+1])
		);
	end

	// back stage: fold the remainder into the band, or pass an in-band sample unchanged; a zero threshold gives zero
	logic signed [W:0]   r_off;
	logic [W-1:0]        r_abs;
	logic signed [W:0]   y_val;
	logic [SAMPLE_BITS-1:0] y_sel;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;

	assign r_off = $signed({1'b0, rem_c[W]}) - $signed({2'b00, thresh_q, 1'b0});
	assign r_abs = r_off[W] ? (W)'(-r_off) : r_off[W-1:0];
	assign y_val = $signed({1'b0, r_abs}) - $signed({3'b000, thresh_q});

	always_comb begin
		if (thresh_q == '0) begin
			y_sel = '0;
		end else if (ctl_c[W].pass) begin
			y_sel = samp_c[W];
		end else begin
			y_sel = y_val[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= y_sel;
		end
	end

	assign folded_ch.valid      = out_valid_q;
	assign folded_ch.sample_out = out_data_q;

`ifndef SYNTH
	logic signed [W-1:0] out_ext;
	logic signed [W-1:0] thr_ext;

	assign out_ext = {folded_ch.sample_out[SAMPLE_BITS-1], folded_ch.sample_out};
	assign thr_ext = $signed({2'b00, thresh_q});

	a_out_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		folded_ch.valid |-> (out_ext <= thr_ext) && (out_ext >= -thr_ext))
		else $error("folded item outside threshold band");

	a_zero_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		folded_ch.valid && (thresh_q == '0) |-> (folded_ch.sample_out == '0))
		else $error("nonzero item with zero threshold");

	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_c[W]) && $stable(ctl_s1))
		else $error("pipeline advanced while output stalled");
`endif

endmodule
